// ===== rtl/nct_pkg.sv =====
// shared types, codes and constants of the neighbour channel table
package nct_pkg;

    // field widths
    localparam int CH_W   = 16;
    localparam int BW_W   = 8;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 10;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int SLOT_W = CH_W + BW_W;

    // default number of table slots
    localparam int TABLE_SIZE_DEF = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    // register indexes
    localparam logic [2:0] REG_PRIORITY  = 3'd0;
    localparam logic [2:0] REG_LOW_THR   = 3'd1;
    localparam logic [2:0] REG_MIN_LEVEL = 3'd2;
    localparam logic [2:0] REG_EMPTY_CH  = 3'd3;
    localparam logic [2:0] REG_NO_BW     = 3'd4;

    // reset values of the code registers, also what an unwritten slot holds
    localparam logic [CH_W-1:0] EMPTY_CH_RST = 16'd666;
    localparam logic [BW_W-1:0] NO_BW_RST    = 8'd255;

    // encoded length pieces
    localparam logic [CNT_W-1:0] LEN_BASE     = 10'd6;
    localparam logic [4:0]       LEN_ENTRY    = 5'd17;
    localparam logic [4:0]       LEN_BW_NONE  = 5'd1;
    localparam logic [4:0]       LEN_BW_GIVEN = 5'd4;
    localparam logic [CNT_W-1:0] LEN_PRIO_ON  = 10'd4;
    localparam logic [CNT_W-1:0] LEN_OPT_OFF  = 10'd1;
    localparam logic [CNT_W-1:0] LEN_THR_ON   = 10'd6;
    localparam logic [CNT_W-1:0] CNT_MAX      = 10'd1023;

    // configuration register values
    typedef struct packed {
        logic            priority_present;
        logic            low_threshold_present;
        logic            min_level_present;
        logic [CH_W-1:0] empty_channel_code;
        logic [BW_W-1:0] no_bandwidth_code;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic issue;
        logic out_load;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_issue;
    } t_dp_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/nct_ram.sv =====
// generic simple dual-port ram with registered read
module nct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/nct_regs.sv =====
// configuration register file behind the apb port
module nct_regs
    import nct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.priority_present      <= 1'b0;
            r_cfg.low_threshold_present <= 1'b0;
            r_cfg.min_level_present     <= 1'b0;
            r_cfg.empty_channel_code    <= EMPTY_CH_RST;
            r_cfg.no_bandwidth_code     <= NO_BW_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PRIORITY:  r_cfg.priority_present      <= pwdata[0];
                REG_LOW_THR:   r_cfg.low_threshold_present <= pwdata[0];
                REG_MIN_LEVEL: r_cfg.min_level_present     <= pwdata[0];
                REG_EMPTY_CH:  r_cfg.empty_channel_code    <= pwdata[CH_W-1:0];
                REG_NO_BW:     r_cfg.no_bandwidth_code     <= pwdata[BW_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PRIORITY:  prdata = DATA_W'(r_cfg.priority_present);
            REG_LOW_THR:   prdata = DATA_W'(r_cfg.low_threshold_present);
            REG_MIN_LEVEL: prdata = DATA_W'(r_cfg.min_level_present);
            REG_EMPTY_CH:  prdata = DATA_W'(r_cfg.empty_channel_code);
            REG_NO_BW:     prdata = DATA_W'(r_cfg.no_bandwidth_code);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/nct_ctrl.sv =====
// controller state machine sequencing the slot scan
module nct_ctrl
    import nct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // output register can take a new item
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SCAN;
            S_SCAN:   if (i_sts.last_issue) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.issue    = (r_state == S_SCAN);
        o_cmd.out_load = (r_state == S_FINISH) && out_free;
        o_in_stall     = (r_state != S_IDLE);
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/nct_dp.sv =====
// datapath: slot ram, scan counter, slot update and length accumulator
module nct_dp
    import nct_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_ctl_cmd         i_cmd,
    output t_dp_sts          o_sts,
    input  logic [CMD_W-1:0] i_cmd_code,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [BW_W-1:0]  i_bandwidth,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_bit_count
);

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // item registers
    logic [CMD_W-1:0] r_cmd;
    logic [CH_W-1:0]  r_ch;
    logic [BW_W-1:0]  r_bw;

    // scan state
    logic [AW-1:0]    r_idx;
    logic             r_proc_vld;
    logic [AW-1:0]    r_proc_addr;
    logic             r_proc_written;
    logic             r_done;
    logic [CNT_W-1:0] r_acc;
    logic             r_valid [TABLE_SIZE];

    // result registers
    logic [ST_W-1:0]  r_status;
    logic [CNT_W-1:0] r_bit_count;

    logic [SLOT_W-1:0] ram_rd_data;
    logic [CH_W-1:0]   slot_ch;
    logic [BW_W-1:0]   slot_bw;
    logic              slot_free;
    logic              hit;
    logic              wr_en;
    logic [CH_W-1:0]   new_ch;
    logic [BW_W-1:0]   new_bw;
    logic [CH_W-1:0]   post_ch;
    logic [BW_W-1:0]   post_bw;
    logic [4:0]        slot_len;
    logic [CNT_W:0]    acc_sum;
    logic [CNT_W-1:0]  start_len;
    logic [ST_W-1:0]   end_status;

    nct_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_proc_addr),
        .i_wr_data ({new_ch, new_bw}),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    assign o_sts.last_issue = (r_idx == AW'(TABLE_SIZE - 1));

    // a slot never written holds the reset codes
    always_comb begin
        if (r_proc_written) begin
            slot_ch = ram_rd_data[SLOT_W-1:BW_W];
            slot_bw = ram_rd_data[BW_W-1:0];
        end else begin
            slot_ch = EMPTY_CH_RST;
            slot_bw = NO_BW_RST;
        end
    end

    // slot update decision
    always_comb begin
        slot_free = (slot_ch == i_cfg.empty_channel_code);
        hit       = 1'b0;
        new_ch    = i_cfg.empty_channel_code;
        new_bw    = i_cfg.no_bandwidth_code;
        wr_en     = 1'b0;
        case (r_cmd)
            CMD_CLEAR: begin
                wr_en = r_proc_vld;
            end
            CMD_ADD: begin
                hit    = !r_done && slot_free;
                new_ch = r_ch;
                new_bw = r_bw;
                wr_en  = r_proc_vld && hit;
            end
            CMD_DELETE: begin
                hit   = !r_done && (slot_ch == r_ch);
                wr_en = r_proc_vld && hit;
            end
            default: ;
        endcase
        post_ch = wr_en ? new_ch : slot_ch;
        post_bw = wr_en ? new_bw : slot_bw;
    end

    // cost of the slot after the command, saturating sum
    always_comb begin
        if (post_ch == i_cfg.empty_channel_code) begin
            slot_len = '0;
        end else if (post_bw == i_cfg.no_bandwidth_code) begin
            slot_len = LEN_ENTRY + LEN_BW_NONE;
        end else begin
            slot_len = LEN_ENTRY + LEN_BW_GIVEN;
        end
        acc_sum = {1'b0, r_acc} + (CNT_W + 1)'(slot_len);
    end

    // fixed part of the length
    always_comb begin
        start_len = LEN_BASE
                  + (i_cfg.priority_present      ? LEN_PRIO_ON : LEN_OPT_OFF)
                  + (i_cfg.low_threshold_present ? LEN_THR_ON  : LEN_OPT_OFF)
                  + (i_cfg.min_level_present     ? LEN_THR_ON  : LEN_OPT_OFF);
    end

    // final status
    always_comb begin
        end_status = ST_OK;
        if (!r_done) begin
            case (r_cmd)
                CMD_ADD:    end_status = ST_FULL;
                CMD_DELETE: end_status = ST_NOT_FOUND;
                default:    end_status = ST_OK;
            endcase
        end
    end

    // item capture and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_proc_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_proc_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_idx  <= '0;
                r_done <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_idx <= r_idx + AW'(1);
                end
                if (r_proc_vld && hit) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd <= i_cmd_code;
            r_ch  <= i_channel;
            r_bw  <= i_bandwidth;
            r_acc <= start_len;
        end else if (r_proc_vld) begin
            r_acc <= acc_sum[CNT_W] ? CNT_MAX : acc_sum[CNT_W-1:0];
        end
        if (i_cmd.issue) begin
            r_proc_addr    <= r_idx;
            r_proc_written <= r_valid[r_idx];
        end
        if (i_cmd.out_load) begin
            r_status    <= end_status;
            r_bit_count <= r_acc;
        end
    end

    // written marks, one per slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_valid[r_proc_addr] <= 1'b1;
        end
    end

    assign o_status    = r_status;
    assign o_bit_count = r_bit_count;

endmodule

// ===== rtl/neighbour_channel_table_top.sv =====
// top level of the neighbour channel table
// Each command item (clear, add, delete) walks the whole slot table once, one
// slot per clock through the single read port of the slot ram, rewriting every
// slot on a clear and otherwise the first free slot (add) or first matching slot
// (delete) on the way, and summing the encoded bit length. The result is loaded
// into the output register once that register is free; the next item can then be
// accepted while the previous result still sits there. Slots never written since
// reset read as channel 666 with bandwidth 255, so no clearing pass is needed.
// Configuration registers sit on an apb port at byte address 4*index and must
// only be written while no item is in flight.
module neighbour_channel_table_top
    import nct_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // command items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [BW_W-1:0]   i_bandwidth,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [CNT_W-1:0]  o_bit_count
);

    t_cfg     cfg;
    t_ctl_cmd ctl_cmd;
    t_dp_sts  dp_sts;

    nct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (ctl_cmd)
    );

    nct_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (ctl_cmd),
        .o_sts       (dp_sts),
        .i_cmd_code  (i_cmd),
        .i_channel   (i_channel),
        .i_bandwidth (i_bandwidth),
        .o_status    (o_status),
        .o_bit_count (o_bit_count)
    );

endmodule

// ===== rtl/nct_checker.sv =====
// port-level checks on the neighbour channel table, bound to the top level
module nct_checker
    import nct_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [ST_W-1:0]  o_status,
    input logic [CNT_W-1:0] o_bit_count
);

    // an accepted item keeps the input side busy while the table is scanned
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_bit_count))
        else $error("stalled result changed");

    // a new result only appears at the end of a scan
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in flight");

    // length never drops below the fixed header cost
    a_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_bit_count >= 10'd9)
        else $error("bit count below minimum");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK) || (o_status == ST_FULL)
            || (o_status == ST_NOT_FOUND))
        else $error("undefined status code");

endmodule

bind neighbour_channel_table_top nct_checker u_nct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_bit_count (o_bit_count)
);

// ===== tb/tb_neighbour_channel_table_top.sv =====
// testbench for the neighbour channel table: command items checked against a local table model
module tb_neighbour_channel_table_top;
    import nct_pkg::*;

    localparam int SLOTS = TABLE_SIZE_DEF;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // expected result of one command item
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] bit_count;
    } t_table_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_cmd;
    logic [CH_W-1:0]   i_channel;
    logic [BW_W-1:0]   i_bandwidth;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [ST_W-1:0]   o_status;
    logic [CNT_W-1:0]  o_bit_count;

    // local copy of the slot table and registers
    logic [CH_W-1:0] chan_slot [SLOTS];
    logic [BW_W-1:0] bw_slot [SLOTS];
    t_cfg            cfg;

    t_table_reply reply_q[$];
    int           err_count = 0;
    bit           quiet = 1'b0;
    int           long_hold = 0;

    neighbour_channel_table_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_channel   (i_channel),
        .i_bandwidth (i_bandwidth),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_bit_count (o_bit_count)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // encoded length of the table under the current codes and flags
    function automatic logic [CNT_W-1:0] table_length();
        int bits;
        bits = 6;
        for (int i = 0; i < SLOTS; i++) begin
            if (chan_slot[i] != cfg.empty_channel_code) begin
                bits += 17;
                bits += (bw_slot[i] == cfg.no_bandwidth_code) ? 1 : 4;
            end
        end
        bits += cfg.priority_present ? 4 : 1;
        bits += cfg.low_threshold_present ? 6 : 1;
        bits += cfg.min_level_present ? 6 : 1;
        if (bits > 1023) begin
            bits = 1023;
        end
        return bits[CNT_W-1:0];
    endfunction

    // apply one command to the local table and return the expected result
    function automatic t_table_reply table_apply(input logic [CMD_W-1:0] cmd,
                                                 input logic [CH_W-1:0] ch,
                                                 input logic [BW_W-1:0] bw);
        t_table_reply r;
        bit           done;
        r.status = ST_OK;
        done = 1'b0;
        case (cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    chan_slot[i] = cfg.empty_channel_code;
                    bw_slot[i] = cfg.no_bandwidth_code;
                end
            end
            CMD_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && chan_slot[i] == cfg.empty_channel_code) begin
                        chan_slot[i] = ch;
                        bw_slot[i] = bw;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    r.status = ST_FULL;
                end
            end
            CMD_DELETE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && chan_slot[i] == ch) begin
                        chan_slot[i] = cfg.empty_channel_code;
                        bw_slot[i] = cfg.no_bandwidth_code;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        r.bit_count = table_length();
        return r;
    endfunction

    // offer one command item, record its expected result once accepted
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                             input logic [BW_W-1:0] bw);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_channel = ch;
        i_bandwidth = bw;
        do @(posedge i_clk); while (o_in_stall);
        reply_q.push_back(table_apply(cmd, ch, bw));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // random item, channels biased toward ones the table holds
    task automatic send_random_item();
        int              pick;
        logic [CMD_W-1:0] cmd;
        logic [CH_W-1:0]  ch;
        logic [BW_W-1:0]  bw;
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            cmd = CMD_CLEAR;
        end else if (pick < 4) begin
            cmd = CMD_SPARE;
        end else if (pick < 59) begin
            cmd = CMD_ADD;
        end else begin
            cmd = CMD_DELETE;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            ch = chan_slot[SLOT_AW'($urandom_range(0, SLOTS - 1))];
        end else if (pick == 4) begin
            ch = cfg.empty_channel_code;
        end else if (pick == 5) begin
            ch = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
            ch = CH_W'($urandom);
        end
        bw = ($urandom_range(0, 9) < 3) ? cfg.no_bandwidth_code : BW_W'($urandom);
        send_item(cmd, ch, bw);
    endtask

    // wait until every expected result has come back
    task automatic wait_drained();
        while (reply_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one apb write, junk above the register width
    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value,
                             input int width);
        logic [DATA_W-1:0] data;
        data = ({$urandom} << width) | value;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PRIORITY:  cfg.priority_present = data[0];
            REG_LOW_THR:   cfg.low_threshold_present = data[0];
            REG_MIN_LEVEL: cfg.min_level_present = data[0];
            REG_EMPTY_CH:  cfg.empty_channel_code = data[CH_W-1:0];
            REG_NO_BW:     cfg.no_bandwidth_code = data[BW_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // write all registers once the block is idle
    task automatic write_config(input bit prio, input bit low_thr, input bit min_lvl,
                                input logic [CH_W-1:0] empty_ch,
                                input logic [BW_W-1:0] no_bw);
        wait_drained();
        apb_write(REG_PRIORITY, DATA_W'(prio), 1);
        apb_write(REG_LOW_THR, DATA_W'(low_thr), 1);
        apb_write(REG_MIN_LEVEL, DATA_W'(min_lvl), 1);
        apb_write(REG_EMPTY_CH, DATA_W'(empty_ch), CH_W);
        apb_write(REG_NO_BW, DATA_W'(no_bw), BW_W);
    endtask

    // field extremes, every command, empty code add and delete, miss on delete
    task automatic test_directed();
        send_item(CMD_SPARE, 16'hFFFF, 8'hFF);
        send_item(CMD_DELETE, 16'd1234, 8'h00);
        send_item(CMD_ADD, 16'h0000, 8'h00);
        send_item(CMD_ADD, 16'hFFFF, 8'hFF);
        send_item(CMD_ADD, 16'h5555, 8'hAA);
        send_item(CMD_ADD, EMPTY_CH_RST, 8'h12);
        send_item(CMD_DELETE, EMPTY_CH_RST, 8'h00);
        send_item(CMD_DELETE, 16'hFFFF, 8'hFF);
        send_item(CMD_ADD, 16'hAAAA, 8'h55);
        send_item(CMD_DELETE, 16'h0000, 8'h00);
        send_item(CMD_DELETE, 16'h0000, 8'h00);
        send_item(CMD_CLEAR, 16'hFFFF, 8'hFF);
        send_item(CMD_ADD, 16'h0000, 8'hFF);
        send_item(CMD_SPARE, 16'h0000, 8'h00);
    endtask

    // codes changed under stored slots, then clear with the new codes
    task automatic test_code_change();
        write_config(1'b0, 1'b0, 1'b0, EMPTY_CH_RST, NO_BW_RST);
        send_item(CMD_CLEAR, 16'h0000, 8'h00);
        send_item(CMD_ADD, 16'h1111, 8'h22);
        send_item(CMD_ADD, 16'h2222, 8'hFF);
        send_item(CMD_ADD, 16'h3333, 8'h44);
        write_config(1'b1, 1'b1, 1'b1, 16'h2222, 8'h22);
        send_item(CMD_SPARE, 16'h3333, 8'h44);
        send_item(CMD_ADD, 16'h5555, 8'h00);
        send_item(CMD_DELETE, 16'h2222, 8'h00);
        send_item(CMD_DELETE, EMPTY_CH_RST, 8'h00);
        send_item(CMD_CLEAR, 16'h1111, 8'h22);
        send_item(CMD_ADD, EMPTY_CH_RST, 8'h01);
        write_config(1'b0, 1'b0, 1'b0, EMPTY_CH_RST, NO_BW_RST);
        send_item(CMD_SPARE, 16'h0000, 8'h00);
    endtask

    // fill past capacity, delete of the empty code when full, then drain
    task automatic test_fill_and_drain();
        logic [CH_W-1:0] ch;
        send_item(CMD_CLEAR, 16'h0000, 8'h00);
        repeat (SLOTS + 3) begin
            ch = CH_W'($urandom);
            if (ch == cfg.empty_channel_code) begin
                ch = ~ch;
            end
            send_item(CMD_ADD, ch, BW_W'($urandom));
        end
        send_item(CMD_DELETE, cfg.empty_channel_code, 8'h00);
        repeat (24) send_item(CMD_DELETE,
                              chan_slot[SLOT_AW'($urandom_range(0, SLOTS - 1))],
                              BW_W'($urandom));
        repeat (8) send_item(CMD_ADD, CH_W'($urandom), BW_W'($urandom));
    endtask

    // result side held off for a long stretch while items keep coming
    task automatic test_backpressure();
        quiet = 1'b1;
        long_hold = 300;
        repeat (40) send_random_item();
        quiet = 1'b0;
        wait_drained();
    endtask

    // sender pauses until everything is back, then resumes
    task automatic test_drain_pause();
        repeat (30) send_random_item();
        wait_drained();
        repeat (30) send_random_item();
    endtask

    // random items under every flag combination and several code settings
    task automatic test_config_sweep();
        logic [CH_W-1:0] empty_ch;
        logic [BW_W-1:0] no_bw;
        for (int p = 0; p < 8; p++) begin
            case (p)
                1: begin
                    empty_ch = 16'h0000;
                    no_bw = 8'h00;
                end
                2: begin
                    empty_ch = 16'hFFFF;
                    no_bw = 8'hFF;
                end
                3: begin
                    empty_ch = EMPTY_CH_RST;
                    no_bw = NO_BW_RST;
                end
                default: begin
                    empty_ch = CH_W'($urandom);
                    no_bw = BW_W'($urandom);
                end
            endcase
            write_config(p[0], p[1], p[2], empty_ch, no_bw);
            quiet = (p == 5);
            repeat (240) send_random_item();
            quiet = 1'b0;
        end
    endtask

    // result side stall, a random hold before each item
    initial begin : result_stall_gen
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 15);
            if (long_hold != 0) begin
                hold = long_hold;
                long_hold = 0;
            end
            i_out_stall = (hold > 0);
            repeat (hold) @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_table_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reply_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, status %0d bit_count %0d",
                         $time, o_status, o_bit_count);
            end else begin
                want = reply_q.pop_front();
                if (o_status !== want.status) begin
                    err_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                end
                if (o_bit_count !== want.bit_count) begin
                    err_count++;
                    $display("%0t: bit_count mismatch, expected %0d, actual %0d",
                             $time, want.bit_count, o_bit_count);
                end
            end
        end
    end

    // run limit
    initial begin : run_limit
        #4000000;
        $display("status: fail");
        $finish;
    end

    // reset, test sequence, verdict
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_cmd = CMD_CLEAR;
        i_channel = '0;
        i_bandwidth = '0;
        cfg.priority_present = 1'b0;
        cfg.low_threshold_present = 1'b0;
        cfg.min_level_present = 1'b0;
        cfg.empty_channel_code = EMPTY_CH_RST;
        cfg.no_bandwidth_code = NO_BW_RST;
        for (int i = 0; i < SLOTS; i++) begin
            chan_slot[i] = EMPTY_CH_RST;
            bw_slot[i] = NO_BW_RST;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_code_change();
        test_fill_and_drain();
        test_backpressure();
        test_drain_pause();
        test_config_sweep();

        wait_drained();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== neighbour_channel_table_top.f =====
rtl/nct_pkg.sv
rtl/nct_ram.sv
rtl/nct_regs.sv
rtl/nct_ctrl.sv
rtl/nct_dp.sv
rtl/neighbour_channel_table_top.sv
rtl/nct_checker.sv
tb/tb_neighbour_channel_table_top.sv
